@@ src/utf8_to_tis620_stream_core_assert.svh @@
// Assertion macros used by the decoder module.
`ifndef UTF8_TO_TIS620_STREAM_CORE_ASSERT_SVH
`define UTF8_TO_TIS620_STREAM_CORE_ASSERT_SVH

// Clocked assertion that is held off while reset is asserted.
`define U2T_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define U2T_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/u2t_pkg.sv @@
package u2t_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 16;
	localparam int CODE_W  = 21;
	localparam int PEND_W  = 2;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// Word index of the max_chars register (paddr[2]).
	localparam logic REG_MAX_CHARS = 1'b0;

	localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = 16'd1999;
	localparam logic [BYTE_W-1:0]  UNMAPPED_CHAR   = 8'h3F;
	// Thai block U+0E00..U+0E7F, matched on codepoint bits [20:7].
	localparam logic [CODE_W-8:0]  THAI_BLOCK      = 14'h001C;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              is_last;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic               has_char;
		logic               end_of_string;
		logic [COUNT_W-1:0] char_total;
	} result_t;

	// TIS-620 code for U+0E00 + idx, zero where the block has no mapping.
	function automatic logic [BYTE_W-1:0] thai_map(input logic [6:0] idx);
		logic [BYTE_W-1:0] code;
		code = 8'hA0 + {1'b0, idx};
		if ((idx >= 7'h01 && idx <= 7'h3A) || (idx >= 7'h3F && idx <= 7'h5B)) begin
			return code;
		end
		return '0;
	endfunction

	// Full codepoint to TIS-620 mapping.
	function automatic logic [BYTE_W-1:0] map_code(input logic [CODE_W-1:0] cp);
		logic [BYTE_W-1:0] t;
		t = thai_map(cp[6:0]);
		if (cp[CODE_W-1:7] == '0) begin
			return {1'b0, cp[6:0]};
		end
		if (cp[CODE_W-1:7] == THAI_BLOCK) begin
			return (t != '0) ? t : UNMAPPED_CHAR;
		end
		return UNMAPPED_CHAR;
	endfunction

endpackage

@@ src/u2t_decode.sv @@
`include "utf8_to_tis620_stream_core_assert.svh"

module u2t_decode import u2t_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  item_t              item,
	input  logic [COUNT_W-1:0] max_chars,
	output logic               res_valid,
	output result_t            res
);

	logic [PEND_W-1:0]  pend_q;
	logic [CODE_W-1:0]  acc_q;
	logic [COUNT_W-1:0] cnt_q;

	logic [PEND_W-1:0]  pend_d;
	logic [CODE_W-1:0]  acc_d;
	logic [COUNT_W-1:0] cnt_d;
	logic [CODE_W-1:0]  acc_shift;
	logic [CODE_W-1:0]  cp;
	logic               done;
	logic               emit;
	logic               ends;
	logic               is_zero;
	logic [BYTE_W-1:0]  b;

	assign b         = item.in_byte;
	assign is_zero   = (b == '0);
	assign ends      = item.is_last || is_zero;
	assign acc_shift = {acc_q[CODE_W-7:0], b[5:0]};

	always_comb begin
		pend_d = pend_q;
		acc_d  = acc_q;
		done   = 1'b0;
		cp     = '0;
		if (!is_zero) begin
			if (pend_q != '0 && b[7:6] == 2'b10) begin
				acc_d  = acc_shift;
				pend_d = pend_q - 2'd1;
				done   = (pend_q == 2'd1);
				cp     = acc_shift;
			end else begin
				pend_d = '0;
				if (b[7] == 1'b0) begin
					done = 1'b1;
					cp   = {{(CODE_W-BYTE_W){1'b0}}, b};
				end else if (b[7:5] == 3'b110) begin
					acc_d  = {{(CODE_W-5){1'b0}}, b[4:0]};
					pend_d = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					acc_d  = {{(CODE_W-4){1'b0}}, b[3:0]};
					pend_d = 2'd2;
				end else if (b[7:3] == 5'b11110) begin
					acc_d  = {{(CODE_W-3){1'b0}}, b[2:0]};
					pend_d = 2'd3;
				end
			end
		end
	end

	assign emit  = done && (cnt_q < max_chars);
	assign cnt_d = emit ? cnt_q + 16'd1 : cnt_q;

	always_comb begin
		res_valid         = emit || ends;
		res.out_byte      = emit ? map_code(cp) : '0;
		res.has_char      = emit;
		res.end_of_string = ends;
		res.char_total    = cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
		end else if (step) begin
			if (ends) begin
				pend_q <= '0;
				acc_q  <= '0;
				cnt_q  <= '0;
			end else begin
				pend_q <= pend_d;
				acc_q  <= acc_d;
				cnt_q  <= cnt_d;
			end
		end
	end

	`U2T_ASSERT(a_mid_result_has_char, (res_valid && !res.end_of_string) |-> res.has_char, "result inside a string carries no character")
	`U2T_ASSERT(a_end_clears_state, (step && ends) |=> (pend_q == '0 && acc_q == '0 && cnt_q == '0), "state not cleared after end of string")
	`U2T_ASSERT(a_count_steps_by_one, (step && emit && !ends) |=> (cnt_q == COUNT_W'($past(cnt_q) + 16'd1)), "character count did not advance by one")

endmodule

@@ src/u2t_out_reg.sv @@
module u2t_out_reg import u2t_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	input  logic    take,
	output logic    valid_q,
	output result_t res_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

@@ src/utf8_to_tis620_stream_core.sv @@
// A byte waits in the input register; its decoded result is registered in the output register.
// Throughput: one byte per cycle unless the output stalls, set by the single decode stage.
// A byte that yields no result retires from the input register without using the output.
// Reset (arst_n low, asynchronous) clears all valid flags and decode state,
// and sets max_chars to 1999.
module utf8_to_tis620_stream_core import u2t_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// Input byte channel.
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BYTE_W-1:0]  in_byte,
	input  logic               is_last,
	// Result channel.
	output logic               out_valid,
	input  logic               out_ready,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               has_char,
	output logic               end_of_string,
	output logic [COUNT_W-1:0] char_total,
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	// Sole configuration register; users write it only while no string is in flight, unenforced.
	logic [COUNT_W-1:0] max_chars_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= MAX_CHARS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_MAX_CHARS) begin
			max_chars_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MAX_CHARS) begin
			prdata = {{(APB_DW-COUNT_W){1'b0}}, max_chars_q};
		end
	end

	// Input register. It holds one byte transaction while the decoder works on it.
	logic    valid_s1;
	item_t   item_s1;
	logic    dec_valid;
	result_t dec_res;
	logic    out_free;
	logic    advance;
	logic    in_take;
	result_t out_res;

	// The output register can take a new result when it is empty or is being drained.
	assign out_free = !out_valid || out_ready;
	// A byte with no result never waits for the output side.
	assign advance  = valid_s1 && (!dec_valid || out_free);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.in_byte <= in_byte;
			item_s1.is_last <= is_last;
		end
	end

	// Decoder: sequence state, codepoint assembly, Thai mapping and the character limit.
	u2t_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.max_chars (max_chars_q),
		.res_valid (dec_valid),
		.res       (dec_res)
	);

	// Result register, which decouples the decoder from a stalled consumer.
	u2t_out_reg u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && dec_valid),
		.res     (dec_res),
		.take    (out_ready),
		.valid_q (out_valid),
		.res_q   (out_res)
	);

	assign out_byte      = out_res.out_byte;
	assign has_char      = out_res.has_char;
	assign end_of_string = out_res.end_of_string;
	assign char_total    = out_res.char_total;

endmodule

@@ tb/utf8_to_tis620_stream_core_tb.sv @@
module utf8_to_tis620_stream_core_tb;
	import u2t_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// A whole string may sit behind a stalled receiver, but the input side never
	// goes this long without a transaction in a healthy run.
	localparam int STALL_LIMIT = 2000;
	// Cycles to let a byte that yields no result retire before a register write.
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_PHASES = 6;
	localparam int BYTES_PER_PHASE = 142;
	localparam logic [APB_AW-1:0] LIMIT_ADDR = {REG_MAX_CHARS, 2'b00};

	// One byte waiting to be driven. When hold is set, the driver keeps the byte
	// back until every result owed so far has been taken from the block.
	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              hold;
	} pending_byte_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [BYTE_W-1:0]  in_byte = '0;
	logic               is_last = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [BYTE_W-1:0]  out_byte;
	logic               has_char;
	logic               end_of_string;
	logic [COUNT_W-1:0] char_total;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [APB_AW-1:0]  paddr = '0;
	logic [APB_DW-1:0]  pwdata = '0;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	utf8_to_tis620_stream_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.is_last       (is_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.has_char      (has_char),
		.end_of_string (end_of_string),
		.char_total    (char_total),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Bytes still to be driven, and the TIS-620 results the block still owes.
	pending_byte_t utf8_pending[$];
	result_t       tis_expected[$];

	// Shadow of the converter state, advanced once per accepted byte.
	logic [PEND_W-1:0]  cont_left = '0;
	logic [CODE_W-1:0]  code_acc = '0;
	logic [COUNT_W-1:0] char_cnt = '0;
	logic [COUNT_W-1:0] char_limit = MAX_CHARS_RESET;

	// Random idle rates in percent for the sender and the receiver.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	// results_due counts results predicted, results_seen counts results taken.
	// Both change only through nonblocking assignments, so the driver sees
	// their pre-edge values no matter which block runs first.
	int results_due = 0;
	int results_seen = 0;
	int stall_cycles = 0;

	int mismatches = 0;
	int bytes_sent = 0;
	int chars_checked = 0;
	int strings_checked = 0;
	int limits_used = 0;
	logic hold_next = 1'b0;

	// TIS-620 code for one codepoint. ASCII passes straight through. In the Thai
	// block, offsets 0x01..0x3A and 0x3F..0x5B land at 0xA0 plus the offset; the
	// rest of the block, and everything outside it, becomes a question mark.
	function automatic logic [BYTE_W-1:0] tis_code(input logic [CODE_W-1:0] cp);
		logic [6:0] off;
		off = cp[6:0];
		if (cp[CODE_W-1:7] == '0) begin
			return {1'b0, off};
		end
		if (cp[CODE_W-1:7] != THAI_BLOCK) begin
			return UNMAPPED_CHAR;
		end
		if ((off >= 7'h01 && off <= 7'h3A) || (off >= 7'h3F && off <= 7'h5B)) begin
			return 8'hA0 + {1'b0, off};
		end
		return UNMAPPED_CHAR;
	endfunction

	// Advances the shadow state by one input byte. Returns 1 and fills res when
	// the byte makes the block produce a result: a character that fits under the
	// limit, or the end of the string (a zero byte or the last flag).
	function automatic bit predict_tis_byte(input logic [BYTE_W-1:0] b, input logic last,
						output result_t res);
		logic               complete;
		logic               emit;
		logic [CODE_W-1:0]  cp;
		logic [BYTE_W-1:0]  ch;
		complete = 1'b0;
		emit = 1'b0;
		cp = '0;
		ch = '0;
		if (b != '0) begin
			if (cont_left != '0 && b[7:6] == 2'b10) begin
				// Continuation byte: six more codepoint bits, high bits fall off.
				code_acc = {code_acc[CODE_W-7:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == '0) begin
					complete = 1'b1;
					cp = code_acc;
				end
			end else begin
				// Anything else starts over; a broken sequence is simply dropped.
				// Stray continuation bytes and 0xF8..0xFF fall through every case.
				cont_left = '0;
				if (!b[7]) begin
					complete = 1'b1;
					cp = {{(CODE_W-BYTE_W){1'b0}}, b};
				end else if (b[7:5] == 3'b110) begin
					code_acc = {{(CODE_W-5){1'b0}}, b[4:0]};
					cont_left = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					code_acc = {{(CODE_W-4){1'b0}}, b[3:0]};
					cont_left = 2'd2;
				end else if (b[7:3] == 5'b11110) begin
					code_acc = {{(CODE_W-3){1'b0}}, b[2:0]};
					cont_left = 2'd3;
				end
			end
			if (complete && char_cnt < char_limit) begin
				ch = tis_code(cp);
				char_cnt = char_cnt + 16'd1;
				emit = 1'b1;
			end
		end
		res.out_byte = ch;
		res.has_char = emit;
		res.end_of_string = 1'b0;
		res.char_total = char_cnt;
		if (last || b == '0) begin
			// End of string: always one result, and any pending sequence is lost.
			res.end_of_string = 1'b1;
			cont_left = '0;
			code_acc = '0;
			char_cnt = '0;
			return 1'b1;
		end
		return emit;
	endfunction

	// Driver. At each edge it first retires the transaction that just completed,
	// predicting its result, then decides whether the next byte goes out. A byte
	// marked hold waits until the block has handed over everything it owes.
	always @(posedge clk or negedge arst_n) begin
		result_t       predicted;
		pending_byte_t nxt;
		int            due_now;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= '0;
			is_last <= 1'b0;
			results_due <= 0;
		end else begin
			due_now = results_due;
			if (in_valid && in_ready) begin
				bytes_sent++;
				if (predict_tis_byte(in_byte, is_last, predicted)) begin
					tis_expected.push_back(predicted);
					due_now++;
				end
			end
			results_due <= due_now;
			if (!in_valid || in_ready) begin
				if (utf8_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct &&
				    (!utf8_pending[0].hold || due_now <= results_seen)) begin
					nxt = utf8_pending.pop_front();
					in_valid <= 1'b1;
					in_byte <= nxt.data;
					is_last <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Every result transaction is checked field by field against the
	// oldest prediction; out_ready is redrawn every cycle at the current rate.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			results_seen <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (tis_expected.size() == 0) begin
					$error("unexpected result: out_byte %0h has_char %0b end %0b total %0d",
					       out_byte, has_char, end_of_string, char_total);
					mismatches++;
				end else begin
					want = tis_expected.pop_front();
					if (out_byte !== want.out_byte) begin
						$error("out_byte: expected %0h, actual %0h", want.out_byte, out_byte);
						mismatches++;
					end
					if (has_char !== want.has_char) begin
						$error("has_char: expected %0b, actual %0b", want.has_char, has_char);
						mismatches++;
					end
					if (end_of_string !== want.end_of_string) begin
						$error("end_of_string: expected %0b, actual %0b",
						       want.end_of_string, end_of_string);
						mismatches++;
					end
					if (char_total !== want.char_total) begin
						$error("char_total: expected %0d, actual %0d",
						       want.char_total, char_total);
						mismatches++;
					end
					chars_checked += want.has_char;
					strings_checked += want.end_of_string;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Watchdog: the input side or the register port must make progress.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((in_valid && in_ready) || psel) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic void queue_byte(input logic [BYTE_W-1:0] b, input logic last);
		pending_byte_t p;
		p.data = b;
		p.last = last;
		p.hold = hold_next;
		hold_next = 1'b0;
		utf8_pending.push_back(p);
	endfunction

	function automatic logic [BYTE_W-1:0] cont_byte();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	// Builds one string of random characters. Most are well-formed: ASCII, Thai
	// three-byte sequences over the whole U+0E00..U+0E7F block, and generic two,
	// three and four byte forms. The rest is noise: stray continuation bytes,
	// 0xF8..0xFF, and sequences cut short. The string ends on a zero byte or on
	// the last flag of its final byte. Returns the number of bytes queued.
	function automatic int queue_random_string();
		logic [BYTE_W-1:0] text[$];
		logic [15:0]       cp;
		int                nchars;
		int                roll;
		int                ncont;
		nchars = $urandom_range(0, 12);
		for (int i = 0; i < nchars; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 25) begin
				text.push_back(8'($urandom_range(1, 127)));
			end else if (roll < 65) begin
				cp = 16'h0E00 + 16'($urandom_range(0, 127));
				text.push_back(8'hE0);
				text.push_back(8'h80 | {2'b00, cp[11:6]});
				text.push_back(8'h80 | {2'b00, cp[5:0]});
			end else if (roll < 73) begin
				text.push_back(8'hC0 | 8'($urandom_range(0, 31)));
				text.push_back(cont_byte());
			end else if (roll < 79) begin
				text.push_back(8'hE0 | 8'($urandom_range(0, 15)));
				repeat (2) text.push_back(cont_byte());
			end else if (roll < 85) begin
				text.push_back(8'hF0 | 8'($urandom_range(0, 7)));
				repeat (3) text.push_back(cont_byte());
			end else if (roll < 90) begin
				text.push_back(cont_byte());
			end else if (roll < 94) begin
				text.push_back(8'($urandom_range(248, 255)));
			end else begin
				// Lead byte followed by too few continuation bytes.
				ncont = $urandom_range(1, 3);
				case (ncont)
					1: text.push_back(8'hC0 | 8'($urandom_range(0, 31)));
					2: text.push_back(8'hE0 | 8'($urandom_range(0, 15)));
					default: text.push_back(8'hF0 | 8'($urandom_range(0, 7)));
				endcase
				repeat ($urandom_range(0, ncont - 1)) text.push_back(cont_byte());
			end
		end
		if (text.size() == 0 || $urandom_range(0, 99) < 30) begin
			for (int i = 0; i < text.size(); i++) begin
				queue_byte(text[i], 1'b0);
			end
			// A zero byte ends the string whether or not the last flag is set.
			queue_byte(8'h00, 1'($urandom_range(0, 1)));
			return text.size() + 1;
		end
		for (int i = 0; i < text.size(); i++) begin
			queue_byte(text[i], i == text.size() - 1);
		end
		return text.size();
	endfunction

	// Waits until every byte has gone in and every result has come out. The
	// polling runs on the falling edge, where nothing else changes.
	task automatic wait_drained();
		while (utf8_pending.size() != 0 || in_valid || tis_expected.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Writes max_chars through the register port and reads it back. Only called
	// with the block idle; the shadow limit follows the write.
	task automatic write_char_limit(input logic [COUNT_W-1:0] limit);
		logic [APB_DW-1:0] readback;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= {{(APB_DW-COUNT_W){1'b0}}, limit};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		char_limit = limit;
		limits_used++;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		readback = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback[COUNT_W-1:0] !== limit) begin
			$error("max_chars: expected %0d, actual %0d", limit, readback[COUNT_W-1:0]);
			mismatches++;
		end
	endtask

	initial begin
		logic [COUNT_W-1:0] limits[RANDOM_PHASES];
		int                 phase_bytes;
		limits[0] = 16'hFFFF;
		limits[1] = 16'd0;
		limits[2] = 16'd1;
		limits[3] = 16'd3;
		limits[4] = 16'($urandom_range(2, 40));
		limits[5] = MAX_CHARS_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed string set, run with max_chars at its reset value: ASCII at the
		// top of its range, a two-byte form outside the Thai block, mapped Thai
		// characters at both ends of the table, an unmapped Thai slot, the largest
		// four-byte codepoint, a stray continuation byte, an invalid lead byte, a
		// sequence broken by an ASCII byte, a zero byte closing the string, and a
		// lead byte left pending when the last flag arrives.
		tx_idle_pct = 26;
		rx_idle_pct = 53;
		queue_byte(8'h41, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'hC2, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hE0, 1'b0);
		queue_byte(8'hB8, 1'b0);
		queue_byte(8'h81, 1'b0);
		queue_byte(8'hE0, 1'b0);
		queue_byte(8'hB9, 1'b0);
		queue_byte(8'h9B, 1'b0);
		queue_byte(8'hE0, 1'b0);
		queue_byte(8'hB8, 1'b0);
		queue_byte(8'hBB, 1'b0);
		queue_byte(8'hF4, 1'b0);
		queue_byte(8'h8F, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hE0, 1'b0);
		queue_byte(8'h41, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hC3, 1'b1);
		wait_drained();

		// Random phases. Each one starts with the block idle and a new limit, from
		// the largest value down to zero and back to the reset value. The idle
		// rates go receiver-heavy, then sender-heavy, then none at all. Halfway
		// through each phase the sender holds off until the block has caught up.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			repeat (SETTLE_CYCLES) @(posedge clk);
			write_char_limit(limits[p]);
			@(negedge clk);
			case (p / 2)
				0: begin
					tx_idle_pct = 26;
					rx_idle_pct = 53;
				end
				1: begin
					tx_idle_pct = 53;
					rx_idle_pct = 26;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			phase_bytes = 0;
			while (phase_bytes < BYTES_PER_PHASE) begin
				if (phase_bytes >= BYTES_PER_PHASE / 2 && phase_bytes < BYTES_PER_PHASE / 2 + 13) begin
					hold_next = 1'b1;
				end
				phase_bytes += queue_random_string();
			end
			wait_drained();
		end

		// Let any straggling result show up before the verdict.
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		@(negedge clk);
		$display("Run covered %0d bytes in %0d strings, %0d characters checked,",
			 bytes_sent, strings_checked, chars_checked);
		$display("over %0d max_chars settings and three idle patterns.", limits_used + 1);
		if (mismatches == 0 && tis_expected.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/u2t_pkg.sv
src/u2t_decode.sv
src/u2t_out_reg.sv
src/utf8_to_tis620_stream_core.sv
tb/utf8_to_tis620_stream_core_tb.sv
